// ===== rtl/core/iol_pkg.sv =====
// ----------------------------------------------------------------------------
// iol_pkg
// Shared types and constants for the indexed ordered list.
// ----------------------------------------------------------------------------
package iol_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 5;
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        FN_INS_HEAD = 3'd0,
        FN_INS_TAIL = 3'd1,
        FN_INS_AT   = 3'd2,
        FN_DEL_HEAD = 3'd3,
        FN_DEL_TAIL = 3'd4,
        FN_DEL_AT   = 3'd5,
        FN_READ     = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic             rd;
        logic             rd_bad;
        logic [IDX_W-1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic load;
        logic from_left;
        logic from_right;
    } t_cell_ctl;

endpackage

// ===== rtl/core/iol_cell.sv =====
// ----------------------------------------------------------------------------
// iol_cell
// One list slot: loads a new value or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module iol_cell
    import iol_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_new,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_value
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    always_comb begin
        priority if (i_ctl.load) begin
            n_value = i_new;
        end else if (i_ctl.from_left) begin
            n_value = i_left;
        end else if (i_ctl.from_right) begin
            n_value = i_right;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/core/iol_ctrl.sv =====
// ----------------------------------------------------------------------------
// iol_ctrl
// Request decode: bound checks, status and the next entry count.
// ----------------------------------------------------------------------------
module iol_ctrl
    import iol_pkg::*;
(
    input  logic [2:0]       i_func,
    input  logic [POS_W-1:0] i_position,
    input  logic [CNT_W-1:0] i_count,
    output t_cmd             o_cmd,
    output t_status          o_status,
    output logic [CNT_W-1:0] o_count
);

    logic [POS_W-1:0] w_pos;
    logic             w_full;
    logic             w_empty;

    assign w_full  = (i_count >= CNT_W'(CAPACITY));
    assign w_empty = (i_count == '0);

    always_comb begin
        o_cmd    = '0;
        o_status = ST_OK;
        w_pos    = i_position;
        unique case (t_func'(i_func))
            FN_INS_HEAD, FN_INS_TAIL, FN_INS_AT: begin
                if (t_func'(i_func) == FN_INS_HEAD) begin
                    w_pos = '0;
                end else if (t_func'(i_func) == FN_INS_TAIL) begin
                    w_pos = i_count;
                end
                if (w_pos > i_count) begin
                    o_status = ST_INVALID;
                end else if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    o_cmd.ins = 1'b1;
                end
            end
            FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_AT: begin
                if (t_func'(i_func) == FN_DEL_HEAD) begin
                    w_pos = '0;
                end else if (t_func'(i_func) == FN_DEL_TAIL) begin
                    w_pos = i_count - CNT_W'(1);
                end
                if (w_empty) begin
                    o_status = ST_EMPTY;
                end else if (w_pos >= i_count) begin
                    o_status = ST_INVALID;
                end else begin
                    o_cmd.del = 1'b1;
                end
            end
            FN_READ: begin
                if (i_position < i_count) begin
                    o_cmd.rd = 1'b1;
                end else begin
                    o_status     = ST_INVALID;
                    o_cmd.rd_bad = 1'b1;
                end
            end
            default: begin
                o_status = ST_INVALID;
            end
        endcase
        o_cmd.pos = w_pos[IDX_W-1:0];
    end

    always_comb begin
        priority if (o_cmd.ins) begin
            o_count = i_count + CNT_W'(1);
        end else if (o_cmd.del) begin
            o_count = i_count - CNT_W'(1);
        end else begin
            o_count = i_count;
        end
    end

endmodule

// ===== rtl/core/indexed_ordered_list_top.sv =====
// ----------------------------------------------------------------------------
// indexed_ordered_list_top
// Bounded ordered list of signed 32-bit values with indexed insert,
// delete and read.
// ----------------------------------------------------------------------------
// At most one request is taken per clock. Each list slot is a cell that can load the
// new value or take its left or right neighbor's entry, so an insert or
// delete shifts every entry above the index in the same cycle. The response
// sits in an output register from the cycle after the request is accepted; a new
// request is taken whenever that register is empty or being drained, so the
// sustained rate is one request per cycle, limited only by the consumer.
module indexed_ordered_list_top
    import iol_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_func,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [CNT_W-1:0]         o_entry_count
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [DATA_W-1:0] r_read_value;
    logic [CNT_W-1:0]  r_entry_count;
    logic              w_acc;
    t_cmd              w_cmd;
    t_status           w_status;
    logic [DATA_W-1:0] w_entry [CAPACITY];
    logic [DATA_W-1:0] w_rd;

    assign o_ready = !r_out_valid || i_ready;
    assign w_acc   = i_valid && o_ready;

    iol_ctrl u_ctrl (
        .i_func     (i_func),
        .i_position (i_position),
        .i_count    (r_count),
        .o_cmd      (w_cmd),
        .o_status   (w_status),
        .o_count    (n_count)
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_cell_ctl         w_ctl;
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        assign w_ctl.load       = w_acc && w_cmd.ins && (w_cmd.pos == IDX_W'(k));
        assign w_ctl.from_left  = w_acc && w_cmd.ins && (IDX_W'(k) > w_cmd.pos);
        assign w_ctl.from_right = w_acc && w_cmd.del && (IDX_W'(k) >= w_cmd.pos);

        if (k == 0) begin : g_first
            assign w_left = w_entry[k];
        end else begin : g_mid_l
            assign w_left = w_entry[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[k];
        end else begin : g_mid_r
            assign w_right = w_entry[k+1];
        end

        iol_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_new   (i_item_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_entry[k])
        );
    end

    always_comb begin
        priority if (w_cmd.rd) begin
            w_rd = w_entry[w_cmd.pos];
        end else if (w_cmd.rd_bad) begin
            w_rd = '1;
        end else begin
            w_rd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status      <= w_status;
            r_read_value  <= w_rd;
            r_entry_count <= n_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_entry_count = r_entry_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_resp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (o_valid && o_entry_count == r_count))
        else $error("response count differs from list count");

    a_fail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_status != ST_OK) |=> (r_count == $past(r_count)))
        else $error("failed request changed the count");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.ins, w_cmd.del, w_cmd.rd, w_cmd.rd_bad}))
        else $error("conflicting decoded operations");
`endif

endmodule
